// ===== rtl/weighted_moving_average_filter_macros.svh =====
// Assertion macros shared by the weighted moving average filter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WEIGHTED_MOVING_AVERAGE_FILTER_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/wma_pkg.sv =====
// Shared types and constants of the weighted moving average filter.
// Depends on nothing; used by wma_div and weighted_moving_average_filter.
package wma_pkg;

  // Fixed field widths of the stream beats.
  localparam int SAMPLE_W = 32;
  localparam int HELD_W   = 4;
  localparam int OUT_W    = 40;

  // Codes carried in the mode flag of an input beat.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FOLD,
    ST_START,
    ST_DIVIDE,
    ST_DELIVER
  } wma_state_t;

  // Status reported by the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } wma_div_st_t;

endpackage

// ===== rtl/wma_div.sv =====
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on wma_pkg; instantiated by weighted_moving_average_filter.
module wma_div
  import wma_pkg::*;
#(
  parameter int DIVIDEND_W = 38,
  parameter int DIVISOR_W  = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,  // signed two's complement
  input  logic [DIVISOR_W-1:0]  divisor,   // unsigned, nonzero, held during the run
  output wma_div_st_t           st,
  output logic [SAMPLE_W-1:0]   quotient
);

  localparam int MAG_W = DIVIDEND_W - 1;
  localparam int CNT_W = $clog2(MAG_W);

  logic [MAG_W-1:0]     mag;
  logic [DIVISOR_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;
  logic                 busy;
  logic                 fix;
  logic                 done;

  logic [DIVISOR_W:0]   trial;
  logic                 fits;
  logic [DIVISOR_W:0]   diff;
  logic [DIVIDEND_W-1:0] abs_val;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial   = {rem, mag[MAG_W-1]};
    fits    = trial >= {1'b0, divisor};
    diff    = trial - {1'b0, divisor};
    abs_val = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
  end

  // Control: run MAG_W steps, then a fix state restores the sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: the magnitude register shifts left and fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIVIDEND_W-1];
      mag <= abs_val[MAG_W-1:0];
      rem <= '0;
    end else if (busy) begin
      mag <= {mag[MAG_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end else if (fix) begin
      quotient <= neg ? (~mag[SAMPLE_W-1:0] + 1'b1) : mag[SAMPLE_W-1:0];
    end
  end

  assign st.busy = busy | fix;
  assign st.done = done;

endmodule

// ===== rtl/weighted_moving_average_filter.sv =====
// Linear weighted moving average over the last WINDOW signed 32-bit samples.
// A sample beat is written into a register ring, then the ring is walked
// newest to oldest, one entry per cycle, keeping a running sum and adding it
// into the weighted sum, so the newest sample gets weight n and the oldest 1.
// The weighted sum is then divided by n(n+1)/2 in a bit-serial divider that
// produces one quotient bit per cycle; the quotient truncates toward zero.
// From acceptance a sample beat passes through the walk, a fold step, the
// divider start, the serial division and its sign fix, and the output load;
// here n is the number of samples held.
// A beat whose tuser is high clears the window and gives no result.
// The next beat is taken while a finished result still waits on the output.
module weighted_moving_average_filter
  import wma_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [31:0] sample
  input  logic                s_axis_tuser,   // [0] mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata    // [31:0] smoothed, [35:32] samples_held
);

`include "weighted_moving_average_filter_macros.svh"

  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int DIV_MAX = WINDOW * (WINDOW + 1) / 2;
  localparam int DIV_W   = $clog2(DIV_MAX + 1);
  localparam int ACC_W   = SAMPLE_W + DIV_W;

  wma_state_t state, state_next;

  logic [SAMPLE_W-1:0] ring [WINDOW];
  logic [IDX_W-1:0]    wpos;
  logic [IDX_W-1:0]    rd;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    step;
  logic [DIV_W-1:0]    dsum;
  logic [ACC_W-1:0]    run;
  logic [ACC_W-1:0]    acc;

  logic                accept;
  logic                take_sample;
  logic                last_step;
  logic                div_start;
  logic                load_out;
  logic [ACC_W-1:0]    rd_ext;
  logic [SAMPLE_W-1:0] rd_val;

  wma_div_st_t         div_st;
  logic [SAMPLE_W-1:0] quotient;

  logic                out_valid;
  logic [SAMPLE_W-1:0] out_smoothed;
  logic [HELD_W-1:0]   out_held;

  assign accept      = s_axis_tvalid & s_axis_tready;
  assign take_sample = accept & (s_axis_tuser == MODE_SAMPLE);
  assign last_step   = (step + CNT_W'(1)) == fill;
  assign rd_val      = ring[rd];
  assign rd_ext      = {{(ACC_W - SAMPLE_W){rd_val[SAMPLE_W-1]}}, rd_val};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (take_sample) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (last_step) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_next = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_st.done) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Ring write position and fill count; a clear beat empties the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
      fill <= '0;
    end else if (accept) begin
      if (s_axis_tuser == MODE_CLEAR) begin
        wpos <= '0;
        fill <= '0;
      end else begin
        wpos <= (wpos == IDX_W'(WINDOW - 1)) ? '0 : wpos + 1'b1;
        if (fill != CNT_W'(WINDOW)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // Sample ring; entries past the fill count are never read.
  always_ff @(posedge clk) begin
    if (take_sample) begin
      ring[wpos] <= s_axis_tdata;
    end
  end

  // Walk newest to oldest: the weighted sum adds the running sum each step.
  always_ff @(posedge clk) begin
    if (take_sample) begin
      rd   <= wpos;
      step <= '0;
      run  <= '0;
      acc  <= '0;
      dsum <= '0;
    end else if (state == ST_WALK) begin
      rd   <= (rd == '0) ? IDX_W'(WINDOW - 1) : rd - 1'b1;
      step <= step + 1'b1;
      run  <= run + rd_ext;
      acc  <= acc + run;
      dsum <= dsum + DIV_W'(step) + DIV_W'(1);
    end else if (state == ST_FOLD) begin
      acc <= acc + run;
    end
  end

  wma_div #(
    .DIVIDEND_W (ACC_W),
    .DIVISOR_W  (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (dsum),
    .st       (div_st),
    .quotient (quotient)
  );

  // Output register; it frees the input side while a beat waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_smoothed <= quotient;
      out_held     <= HELD_W'(fill);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - SAMPLE_W - HELD_W){1'b0}}, out_held, out_smoothed};

  // Checks on the sequencer and the divider hand-off.
  `WMA_ASSERT_NOW(fill_bounded, clk, rst, 1'b1, fill <= CNT_W'(WINDOW))
  `WMA_ASSERT_NOW(walk_in_window, clk, rst, state == ST_WALK, step < fill)
  `WMA_ASSERT_NOW(div_owned, clk, rst, div_st.busy || div_st.done, state == ST_DIVIDE)
  `WMA_ASSERT_NEXT(sample_starts_walk, clk, rst, take_sample, state == ST_WALK)
  `WMA_ASSERT_NEXT(load_sets_valid, clk, rst, load_out, m_axis_tvalid)

endmodule
